### design/presence_alert_publish_controller_unit_assert.svh
// Assertion macros for the presence alert publish controller.
`ifndef PRESENCE_ALERT_PUBLISH_CONTROLLER_UNIT_ASSERT_SVH
`define PRESENCE_ALERT_PUBLISH_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PAPCU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PAPCU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/papcu_pkg.sv
// Shared types, register indexes and constants of the presence alert publish controller.
package papcu_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 8;
    localparam int TIME_WIDTH_DEFAULT  = 32;

    localparam int PADDR_WIDTH = 5;
    localparam int PDATA_WIDTH = 32;

    localparam int MINUTE_WIDTH = 11;
    localparam int LIMIT_WIDTH  = 12;   // holds 60 minutes in seconds

    localparam logic [MINUTE_WIDTH-1:0] MINUTES_PER_DAY    = MINUTE_WIDTH'(1440);
    localparam logic [MINUTE_WIDTH-1:0] START_MINUTE_RESET = MINUTE_WIDTH'(18 * 60);
    localparam logic [MINUTE_WIDTH-1:0] END_MINUTE_RESET   = MINUTE_WIDTH'(6 * 60);

    localparam logic [4:0] TRANS_SEC_MIN   = 5'd2;
    localparam logic [4:0] TRANS_SEC_MAX   = 5'd20;
    localparam logic [5:0] HB_MIN_MIN      = 6'd5;
    localparam logic [5:0] HB_MIN_MAX      = 6'd60;
    localparam logic [8:0] ACT_INT_SEC_MIN = 9'd60;
    localparam logic [8:0] ACT_INT_SEC_MAX = 9'd300;

    localparam logic [LIMIT_WIDTH-1:0] SECONDS_PER_MINUTE = LIMIT_WIDTH'(60);

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SCHED_EN    = 3'd0;
    localparam logic [2:0] REG_START_MIN   = 3'd1;
    localparam logic [2:0] REG_END_MIN     = 3'd2;
    localparam logic [2:0] REG_TRANS_SEC   = 3'd3;
    localparam logic [2:0] REG_HB_MIN      = 3'd4;
    localparam logic [2:0] REG_ACT_INT_SEC = 3'd5;

    // Event kinds
    localparam logic [1:0] KIND_SAMPLE      = 2'd0;
    localparam logic [1:0] KIND_POLL        = 2'd1;
    localparam logic [1:0] KIND_MARK_DONE   = 2'd2;
    localparam logic [1:0] KIND_RESET_TIMER = 2'd3;

    typedef struct packed {
        logic                    sched_en;
        logic [MINUTE_WIDTH-1:0] start_min;
        logic [MINUTE_WIDTH-1:0] end_min;
        logic [4:0]              trans_sec;
        logic [5:0]              hb_min;
        logic [8:0]              act_int_sec;
    } cfg_t;

endpackage

### design/presence_alert_publish_controller_unit.sv
// Top level of the presence alert publish controller: event register, core, result register.
// An accepted event passes the event register, then the result register, on its way to m_*.
// Throughput: one event per cycle unless m_ready stalls; the two registers overlap work.
// Reset: aresetn is synchronous, active low; clears valids, detection/publish state,
// and restores the configuration registers to their defaults.
`include "presence_alert_publish_controller_unit_assert.svh"
module presence_alert_publish_controller_unit #(
    parameter int COUNT_WIDTH = papcu_pkg::COUNT_WIDTH_DEFAULT,
    parameter int TIME_WIDTH  = papcu_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [papcu_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [papcu_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [papcu_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                              pready,
    // Event channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [TIME_WIDTH-1:0]             s_now_seconds,
    input  logic [papcu_pkg::MINUTE_WIDTH-1:0] s_minute_of_day,
    input  logic [COUNT_WIDTH-1:0]            s_total_count,
    input  logic [COUNT_WIDTH-1:0]            s_first_count,
    input  logic [COUNT_WIDTH-1:0]            s_second_count,
    input  logic [COUNT_WIDTH-1:0]            s_third_count,
    input  logic                              s_mark_heartbeat,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_publish_due,
    output logic                              m_heartbeat_flag,
    output logic                              m_active,
    output logic                              m_pending,
    output logic [COUNT_WIDTH-1:0]            m_publish_total,
    output logic [COUNT_WIDTH-1:0]            m_publish_first,
    output logic [COUNT_WIDTH-1:0]            m_publish_second,
    output logic [COUNT_WIDTH-1:0]            m_publish_third,
    output logic [TIME_WIDTH-1:0]             m_next_publish_time,
    output logic [TIME_WIDTH-1:0]             m_alert_time_reported
);
    import papcu_pkg::*;

    cfg_t cfg;

    // Event register (stage 1)
    logic                    in_valid_reg, in_valid_next;
    logic [1:0]              kind_reg;
    logic [TIME_WIDTH-1:0]   now_reg;
    logic [MINUTE_WIDTH-1:0] minute_reg;
    logic [COUNT_WIDTH-1:0]  total_reg, first_reg, second_reg, third_reg;
    logic                    mark_hb_reg;

    // Result register (stage 2)
    logic                    out_valid_reg, out_valid_next;
    logic                    should_pub_reg, is_hb_reg, active_reg, pending_reg;
    logic [COUNT_WIDTH-1:0]  pub_total_reg, pub_first_reg, pub_second_reg, pub_third_reg;
    logic [TIME_WIDTH-1:0]   next_time_reg, alert_time_reg;

    // Core results for the event in stage 1
    logic                    c_should_pub, c_is_hb, c_active, c_pending;
    logic [COUNT_WIDTH-1:0]  c_total, c_first, c_second, c_third;
    logic [TIME_WIDTH-1:0]   c_next_time, c_alert_time;

    logic take_in;  // event transfer into stage 1
    logic fire;     // stage 1 event commits: state updates, result captured

    assign pready  = 1'b1;
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign take_in = s_valid && s_ready;

    assign in_valid_next  = take_in ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    papcu_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    papcu_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_core (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .fire                (fire),
        .cfg                 (cfg),
        .kind                (kind_reg),
        .now_seconds         (now_reg),
        .minute_of_day       (minute_reg),
        .total_count         (total_reg),
        .first_count         (first_reg),
        .second_count        (second_reg),
        .third_count         (third_reg),
        .mark_heartbeat      (mark_hb_reg),
        .publish_due         (c_should_pub),
        .heartbeat_flag      (c_is_hb),
        .active              (c_active),
        .pending             (c_pending),
        .publish_total       (c_total),
        .publish_first       (c_first),
        .publish_second      (c_second),
        .publish_third       (c_third),
        .next_publish_time   (c_next_time),
        .alert_time_reported (c_alert_time)
    );

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Event payload: loaded on each accepted transfer
    always_ff @(posedge aclk) begin
        if (take_in) begin
            kind_reg    <= s_kind;
            now_reg     <= s_now_seconds;
            minute_reg  <= s_minute_of_day;
            total_reg   <= s_total_count;
            first_reg   <= s_first_count;
            second_reg  <= s_second_count;
            third_reg   <= s_third_count;
            mark_hb_reg <= s_mark_heartbeat;
        end
    end

    // Result payload: loaded when the stage 1 event commits
    always_ff @(posedge aclk) begin
        if (fire) begin
            should_pub_reg <= c_should_pub;
            is_hb_reg      <= c_is_hb;
            active_reg     <= c_active;
            pending_reg    <= c_pending;
            pub_total_reg  <= c_total;
            pub_first_reg  <= c_first;
            pub_second_reg <= c_second;
            pub_third_reg  <= c_third;
            next_time_reg  <= c_next_time;
            alert_time_reg <= c_alert_time;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_publish_due         = should_pub_reg;
    assign m_heartbeat_flag      = is_hb_reg;
    assign m_active              = active_reg;
    assign m_pending             = pending_reg;
    assign m_publish_total       = pub_total_reg;
    assign m_publish_first       = pub_first_reg;
    assign m_publish_second      = pub_second_reg;
    assign m_publish_third       = pub_third_reg;
    assign m_next_publish_time   = next_time_reg;
    assign m_alert_time_reported = alert_time_reg;

    // A heartbeat result never carries a record and never comes from the active state
    `PAPCU_ASSERT_NOW(a_hb_no_record, aclk, aresetn, m_valid && m_heartbeat_flag, m_publish_total == '0 && !m_active, "heartbeat result carries record or active")
    // An alert is only due while active with a nonzero max record
    `PAPCU_ASSERT_NOW(a_alert_has_record, aclk, aresetn, m_valid && m_publish_due && !m_heartbeat_flag, m_active && m_publish_total != '0, "alert due without active record")
    // A stalled event in stage 1 stays there
    `PAPCU_ASSERT_NEXT(a_stage1_holds, aclk, aresetn, in_valid_reg && !fire, in_valid_reg, "stage 1 event lost while stalled")
    // Pending is only ever set together with active
    `PAPCU_ASSERT_NOW(a_pending_active, aclk, aresetn, m_valid && m_pending, m_active, "pending without active")

endmodule

### design/papcu_cfg.sv
// APB configuration register file: timing writes saturate, out-of-range minute writes load the reset defaults.
module papcu_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [papcu_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [papcu_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [papcu_pkg::PDATA_WIDTH-1:0] prdata,
    output papcu_pkg::cfg_t                   cfg
);
    import papcu_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic [MINUTE_WIDTH-1:0] wr_min;
    logic [4:0] wr_trans;
    logic [5:0] wr_hb;
    logic [8:0] wr_ai;

    assign reg_idx  = paddr[PADDR_WIDTH-1:2];
    assign wr_en    = psel && penable && pwrite;
    assign wr_min   = pwdata[MINUTE_WIDTH-1:0];
    assign wr_trans = pwdata[4:0];
    assign wr_hb    = pwdata[5:0];
    assign wr_ai    = pwdata[8:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_SCHED_EN: cfg_next.sched_en = pwdata[0];
                REG_START_MIN: begin
                    cfg_next.start_min = (wr_min < MINUTES_PER_DAY) ? wr_min : START_MINUTE_RESET;
                end
                REG_END_MIN: begin
                    cfg_next.end_min = (wr_min < MINUTES_PER_DAY) ? wr_min : END_MINUTE_RESET;
                end
                REG_TRANS_SEC: begin
                    cfg_next.trans_sec = (wr_trans < TRANS_SEC_MIN) ? TRANS_SEC_MIN :
                                         (wr_trans > TRANS_SEC_MAX) ? TRANS_SEC_MAX : wr_trans;
                end
                REG_HB_MIN: begin
                    cfg_next.hb_min = (wr_hb < HB_MIN_MIN) ? HB_MIN_MIN :
                                      (wr_hb > HB_MIN_MAX) ? HB_MIN_MAX : wr_hb;
                end
                REG_ACT_INT_SEC: begin
                    cfg_next.act_int_sec = (wr_ai < ACT_INT_SEC_MIN) ? ACT_INT_SEC_MIN :
                                           (wr_ai > ACT_INT_SEC_MAX) ? ACT_INT_SEC_MAX : wr_ai;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sched_en    <= 1'b0;
            cfg_reg.start_min   <= START_MINUTE_RESET;
            cfg_reg.end_min     <= END_MINUTE_RESET;
            cfg_reg.trans_sec   <= TRANS_SEC_MIN;
            cfg_reg.hb_min      <= HB_MIN_MIN;
            cfg_reg.act_int_sec <= ACT_INT_SEC_MIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCHED_EN:    prdata = PDATA_WIDTH'(cfg_reg.sched_en);
            REG_START_MIN:   prdata = PDATA_WIDTH'(cfg_reg.start_min);
            REG_END_MIN:     prdata = PDATA_WIDTH'(cfg_reg.end_min);
            REG_TRANS_SEC:   prdata = PDATA_WIDTH'(cfg_reg.trans_sec);
            REG_HB_MIN:      prdata = PDATA_WIDTH'(cfg_reg.hb_min);
            REG_ACT_INT_SEC: prdata = PDATA_WIDTH'(cfg_reg.act_int_sec);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### design/papcu_core.sv
// Detection/publish state and the single-pass event update logic.
module papcu_core #(
    parameter int COUNT_WIDTH = papcu_pkg::COUNT_WIDTH_DEFAULT,
    parameter int TIME_WIDTH  = papcu_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fire,
    input  papcu_pkg::cfg_t                   cfg,
    input  logic [1:0]                        kind,
    input  logic [TIME_WIDTH-1:0]             now_seconds,
    input  logic [papcu_pkg::MINUTE_WIDTH-1:0] minute_of_day,
    input  logic [COUNT_WIDTH-1:0]            total_count,
    input  logic [COUNT_WIDTH-1:0]            first_count,
    input  logic [COUNT_WIDTH-1:0]            second_count,
    input  logic [COUNT_WIDTH-1:0]            third_count,
    input  logic                              mark_heartbeat,
    output logic                              publish_due,
    output logic                              heartbeat_flag,
    output logic                              active,
    output logic                              pending,
    output logic [COUNT_WIDTH-1:0]            publish_total,
    output logic [COUNT_WIDTH-1:0]            publish_first,
    output logic [COUNT_WIDTH-1:0]            publish_second,
    output logic [COUNT_WIDTH-1:0]            publish_third,
    output logic [TIME_WIDTH-1:0]             next_publish_time,
    output logic [TIME_WIDTH-1:0]             alert_time_reported
);
    import papcu_pkg::*;

    // State
    logic [COUNT_WIDTH-1:0] rec_total_reg, rec_first_reg, rec_second_reg, rec_third_reg;
    logic [COUNT_WIDTH-1:0] rec_total_next, rec_first_next, rec_second_next, rec_third_next;
    logic active_reg, pending_reg, detect_reg, idle_notice_reg;
    logic active_next, pending_next, detect_next, idle_notice_next;
    logic [TIME_WIDTH-1:0] detect_start_reg, clear_start_reg, last_alert_reg;
    logic [TIME_WIDTH-1:0] detect_start_next, clear_start_next, last_alert_next;
    logic [TIME_WIDTH-1:0] last_hb_reg, last_act_pub_reg;
    logic [TIME_WIDTH-1:0] last_hb_next, last_act_pub_next;

    logic                   window_ok;
    logic [LIMIT_WIDTH-1:0] hb_limit;
    logic [TIME_WIDTH-1:0]  trans_lim, hb_lim, ai_lim;
    logic                   due;

    function automatic logic elapsed(input logic [TIME_WIDTH-1:0] t_now,
                                     input logic [TIME_WIDTH-1:0] since,
                                     input logic [TIME_WIDTH-1:0] limit);
        elapsed = (t_now >= since) && ((t_now - since) >= limit);
    endfunction

    function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                      input logic [TIME_WIDTH-1:0] b);
        logic [TIME_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[TIME_WIDTH] ? '1 : s[TIME_WIDTH-1:0];
    endfunction

    assign hb_limit  = LIMIT_WIDTH'(cfg.hb_min) * SECONDS_PER_MINUTE;
    assign trans_lim = TIME_WIDTH'(cfg.trans_sec);
    assign hb_lim    = TIME_WIDTH'(hb_limit);
    assign ai_lim    = TIME_WIDTH'(cfg.act_int_sec);

    always_comb begin
        if (!cfg.sched_en || cfg.start_min == cfg.end_min) begin
            window_ok = 1'b1;
        end else if (cfg.start_min < cfg.end_min) begin
            window_ok = (minute_of_day >= cfg.start_min) && (minute_of_day < cfg.end_min);
        end else begin
            window_ok = (minute_of_day >= cfg.start_min) || (minute_of_day < cfg.end_min);
        end
    end

    always_comb begin
        rec_total_next    = rec_total_reg;
        rec_first_next    = rec_first_reg;
        rec_second_next   = rec_second_reg;
        rec_third_next    = rec_third_reg;
        active_next       = active_reg;
        pending_next      = pending_reg;
        detect_next       = detect_reg;
        idle_notice_next  = idle_notice_reg;
        detect_start_next = detect_start_reg;
        clear_start_next  = clear_start_reg;
        last_alert_next   = last_alert_reg;
        last_hb_next      = last_hb_reg;
        last_act_pub_next = last_act_pub_reg;
        due               = 1'b0;

        case (kind)
            KIND_SAMPLE: begin
                if (!window_ok) begin
                    rec_total_next    = '0;
                    rec_first_next    = '0;
                    rec_second_next   = '0;
                    rec_third_next    = '0;
                    if (active_reg || detect_reg) begin
                        idle_notice_next = 1'b1;
                    end
                    active_next       = 1'b0;
                    pending_next      = 1'b0;
                    detect_next       = 1'b0;
                    detect_start_next = '0;
                    clear_start_next  = '0;
                end else if (total_count != '0) begin
                    clear_start_next = '0;
                    if (!detect_reg) begin
                        detect_next       = 1'b1;
                        detect_start_next = now_seconds;
                    end
                    if (!active_reg && detect_start_next != '0 &&
                        elapsed(now_seconds, detect_start_next, trans_lim)) begin
                        active_next      = 1'b1;
                        pending_next     = 1'b1;
                        idle_notice_next = 1'b0;
                        rec_total_next   = '0;
                        rec_first_next   = '0;
                        rec_second_next  = '0;
                        rec_third_next   = '0;
                    end
                    if (active_next && total_count > rec_total_next) begin
                        rec_total_next  = total_count;
                        rec_first_next  = first_count;
                        rec_second_next = second_count;
                        rec_third_next  = third_count;
                    end
                end else begin
                    detect_next       = 1'b0;
                    detect_start_next = '0;
                    if (active_reg) begin
                        if (clear_start_reg == '0) begin
                            clear_start_next = now_seconds;
                        end
                        if (elapsed(now_seconds, clear_start_next, trans_lim)) begin
                            active_next      = 1'b0;
                            pending_next     = 1'b0;
                            idle_notice_next = 1'b1;
                            rec_total_next   = '0;
                            rec_first_next   = '0;
                            rec_second_next  = '0;
                            rec_third_next   = '0;
                        end
                    end
                end
            end
            KIND_POLL: begin
                if (active_reg) begin
                    due = (rec_total_reg != '0) &&
                          (pending_reg || last_act_pub_reg == '0 ||
                           elapsed(now_seconds, last_act_pub_reg, ai_lim));
                end else begin
                    due = idle_notice_reg || last_hb_reg == '0 ||
                          elapsed(now_seconds, last_hb_reg, hb_lim);
                end
            end
            KIND_MARK_DONE: begin
                if (mark_heartbeat) begin
                    last_hb_next     = now_seconds;
                    idle_notice_next = 1'b0;
                end else begin
                    pending_next      = 1'b0;
                    last_alert_next   = now_seconds;
                    last_act_pub_next = now_seconds;
                    rec_total_next    = '0;
                    rec_first_next    = '0;
                    rec_second_next   = '0;
                    rec_third_next    = '0;
                end
            end
            KIND_RESET_TIMER: begin
                last_alert_next   = '0;
                last_hb_next      = '0;
                last_act_pub_next = '0;
                if (active_reg) begin
                    pending_next = 1'b1;
                end else begin
                    idle_notice_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result fields, taken from the state after the event
    always_comb begin
        publish_due         = due;
        heartbeat_flag      = (kind == KIND_POLL) && !active_reg;
        active              = active_next;
        pending             = pending_next;
        publish_total       = heartbeat_flag ? '0 : rec_total_next;
        publish_first       = heartbeat_flag ? '0 : rec_first_next;
        publish_second      = heartbeat_flag ? '0 : rec_second_next;
        publish_third       = heartbeat_flag ? '0 : rec_third_next;
        alert_time_reported = last_alert_next;
        if (active_next) begin
            if (pending_next && rec_total_next != '0) begin
                next_publish_time = now_seconds;
            end else if (last_act_pub_next != '0) begin
                next_publish_time = sat_add(last_act_pub_next, ai_lim);
            end else begin
                next_publish_time = now_seconds;
            end
        end else if (idle_notice_next) begin
            next_publish_time = now_seconds;
        end else if (last_hb_next != '0) begin
            next_publish_time = sat_add(last_hb_next, hb_lim);
        end else begin
            next_publish_time = now_seconds;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_total_reg    <= '0;
            rec_first_reg    <= '0;
            rec_second_reg   <= '0;
            rec_third_reg    <= '0;
            active_reg       <= 1'b0;
            pending_reg      <= 1'b0;
            detect_reg       <= 1'b0;
            idle_notice_reg  <= 1'b0;
            detect_start_reg <= '0;
            clear_start_reg  <= '0;
            last_alert_reg   <= '0;
            last_hb_reg      <= '0;
            last_act_pub_reg <= '0;
        end else if (fire) begin
            rec_total_reg    <= rec_total_next;
            rec_first_reg    <= rec_first_next;
            rec_second_reg   <= rec_second_next;
            rec_third_reg    <= rec_third_next;
            active_reg       <= active_next;
            pending_reg      <= pending_next;
            detect_reg       <= detect_next;
            idle_notice_reg  <= idle_notice_next;
            detect_start_reg <= detect_start_next;
            clear_start_reg  <= clear_start_next;
            last_alert_reg   <= last_alert_next;
            last_hb_reg      <= last_hb_next;
            last_act_pub_reg <= last_act_pub_next;
        end
    end

endmodule

### verif/testbench.sv
// Self-checking testbench for the presence alert publish controller top level.
`timescale 1ns / 100ps

module testbench;
    import papcu_pkg::*;

    localparam int CNT_W = COUNT_WIDTH_DEFAULT;
    localparam int TIM_W = TIME_WIDTH_DEFAULT;

    // Generous bound for ~1700 events at worst-case gaps and stalls.
    localparam int CYCLE_LIMIT     = 250_000;
    localparam int RANDOM_SETTINGS = 4;
    localparam int EVENTS_PER_SET  = 205;
    localparam int DRAIN_CYCLES    = 8;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    localparam logic [2:0] REG_ORDER [6] = '{REG_SCHED_EN, REG_START_MIN, REG_END_MIN,
                                             REG_TRANS_SEC, REG_HB_MIN, REG_ACT_INT_SEC};

    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] first;
        logic [CNT_W-1:0] second;
        logic [CNT_W-1:0] third;
    } tally_t;

    typedef struct {
        logic [1:0]              kind;
        logic [TIM_W-1:0]        now;
        logic [MINUTE_WIDTH-1:0] minute;
        tally_t                  counts;
        logic                    mark_hb;
    } event_t;

    typedef struct {
        logic             due;
        logic             heartbeat;
        logic             alert_on;
        logic             owed;
        tally_t           peak;
        logic [TIM_W-1:0] next_due;
        logic [TIM_W-1:0] alert_at;
    } verdict_t;

    // ---------------------------------------------------------------- DUT ports
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr   = '0;
    logic [PDATA_WIDTH-1:0] pwdata  = '0;
    logic [PDATA_WIDTH-1:0] prdata;
    logic                   pready;

    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_kind           = KIND_SAMPLE;
    logic [TIM_W-1:0]        s_now_seconds    = '0;
    logic [MINUTE_WIDTH-1:0] s_minute_of_day  = '0;
    logic [CNT_W-1:0]        s_total_count    = '0;
    logic [CNT_W-1:0]        s_first_count    = '0;
    logic [CNT_W-1:0]        s_second_count   = '0;
    logic [CNT_W-1:0]        s_third_count    = '0;
    logic                    s_mark_heartbeat = 1'b0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_publish_due;
    logic             m_heartbeat_flag;
    logic             m_active;
    logic             m_pending;
    logic [CNT_W-1:0] m_publish_total;
    logic [CNT_W-1:0] m_publish_first;
    logic [CNT_W-1:0] m_publish_second;
    logic [CNT_W-1:0] m_publish_third;
    logic [TIM_W-1:0] m_next_publish_time;
    logic [TIM_W-1:0] m_alert_time_reported;

    presence_alert_publish_controller_unit i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_kind                (s_kind),
        .s_now_seconds         (s_now_seconds),
        .s_minute_of_day       (s_minute_of_day),
        .s_total_count         (s_total_count),
        .s_first_count         (s_first_count),
        .s_second_count        (s_second_count),
        .s_third_count         (s_third_count),
        .s_mark_heartbeat      (s_mark_heartbeat),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_publish_due         (m_publish_due),
        .m_heartbeat_flag      (m_heartbeat_flag),
        .m_active              (m_active),
        .m_pending             (m_pending),
        .m_publish_total       (m_publish_total),
        .m_publish_first       (m_publish_first),
        .m_publish_second      (m_publish_second),
        .m_publish_third       (m_publish_third),
        .m_next_publish_time   (m_next_publish_time),
        .m_alert_time_reported (m_alert_time_reported)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------ predictor state
    // Configuration as the block should hold it (reset values).
    logic                    sched_on      = 1'b0;
    logic [MINUTE_WIDTH-1:0] win_open      = START_MINUTE_RESET;
    logic [MINUTE_WIDTH-1:0] win_close     = END_MINUTE_RESET;
    logic [4:0]              debounce_s    = TRANS_SEC_MIN;
    logic [5:0]              hb_period_min = HB_MIN_MIN;
    logic [8:0]              alert_gap_s   = ACT_INT_SEC_MIN;

    // Detection and publish bookkeeping, all zero out of reset.
    tally_t           peak           = '0;
    logic             alert_on       = 1'b0;
    logic             alert_owed     = 1'b0;
    logic             detecting      = 1'b0;
    logic             idle_owed      = 1'b0;
    logic [TIM_W-1:0] detect_since   = '0;
    logic [TIM_W-1:0] clear_since    = '0;
    logic [TIM_W-1:0] last_alert_at  = '0;
    logic [TIM_W-1:0] last_hb_at     = '0;
    logic [TIM_W-1:0] last_repeat_at = '0;

    // ------------------------------------------------------ bench bookkeeping
    verdict_t awaited_verdicts [$];
    int       cycle_count  = 0;
    int       mismatches   = 0;
    int       events_sent  = 0;
    int       results_seen = 0;
    int       alerts_due   = 0;
    int       beats_due    = 0;
    int       activations  = 0;
    int       run_left [2] = '{0, 0};
    bit       run_calm [2] = '{1'b0, 1'b0};

    // Random traffic shaping
    logic [TIM_W-1:0]        t_now        = '0;
    logic [MINUTE_WIDTH-1:0] minute_cur   = '0;
    bit                      presence     = 1'b0;
    bit                      last_poll_hb = 1'b1;

    // ------------------------------------------------------ predictor
    function automatic int saturate(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Interval counts only when time moved forward by at least the limit.
    function automatic bit held_for(input logic [TIM_W-1:0] now, input logic [TIM_W-1:0] since,
                                    input logic [TIM_W-1:0] limit);
        return now >= since && (now - since) >= limit;
    endfunction

    function automatic logic [TIM_W-1:0] capped_sum(input logic [TIM_W-1:0] a,
                                                    input logic [TIM_W-1:0] b);
        logic [TIM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIM_W] ? '1 : s[TIM_W-1:0];
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_SCHED_EN:    sched_on = val[0];
            REG_START_MIN:   win_open = (val[10:0] < MINUTES_PER_DAY) ? val[10:0]
                                                                      : START_MINUTE_RESET;
            REG_END_MIN:     win_close = (val[10:0] < MINUTES_PER_DAY) ? val[10:0]
                                                                       : END_MINUTE_RESET;
            REG_TRANS_SEC:   debounce_s = 5'(saturate(val[4:0], TRANS_SEC_MIN, TRANS_SEC_MAX));
            REG_HB_MIN:      hb_period_min = 6'(saturate(val[5:0], HB_MIN_MIN, HB_MIN_MAX));
            REG_ACT_INT_SEC: alert_gap_s = 9'(saturate(val[8:0], ACT_INT_SEC_MIN,
                                                        ACT_INT_SEC_MAX));
            default: ;
        endcase
    endfunction

    // Equal bounds open the whole day; start above end wraps past midnight.
    function automatic bit window_open(input logic [MINUTE_WIDTH-1:0] minute);
        if (!sched_on || win_open == win_close)
            return 1'b1;
        if (win_open < win_close)
            return minute >= win_open && minute < win_close;
        return minute >= win_open || minute < win_close;
    endfunction

    function automatic void take_sample(input event_t ev);
        if (!window_open(ev.minute)) begin
            peak = '0;
            if (alert_on || detecting)
                idle_owed = 1'b1;
            alert_on     = 1'b0;
            alert_owed   = 1'b0;
            detecting    = 1'b0;
            detect_since = '0;
            clear_since  = '0;
        end else if (ev.counts.total != 0) begin
            clear_since = '0;
            if (!detecting) begin
                detecting    = 1'b1;
                detect_since = ev.now;
            end
            // a detection started at time zero never counts as started
            if (!alert_on && detect_since != 0 && held_for(ev.now, detect_since, debounce_s)) begin
                alert_on   = 1'b1;
                alert_owed = 1'b1;
                idle_owed  = 1'b0;
                peak       = '0;
                activations++;
            end
            if (alert_on && ev.counts.total > peak.total)
                peak = ev.counts;
        end else begin
            detecting    = 1'b0;
            detect_since = '0;
            if (alert_on) begin
                if (clear_since == 0)
                    clear_since = ev.now;
                if (held_for(ev.now, clear_since, debounce_s)) begin
                    alert_on   = 1'b0;
                    alert_owed = 1'b0;
                    idle_owed  = 1'b1;
                    peak       = '0;
                end
            end
        end
    endfunction

    function automatic bit publish_is_due(input logic [TIM_W-1:0] now);
        if (alert_on) begin
            if (peak.total == 0)
                return 1'b0;
            if (alert_owed || last_repeat_at == 0)
                return 1'b1;
            return held_for(now, last_repeat_at, alert_gap_s);
        end
        return idle_owed || last_hb_at == 0 || held_for(now, last_hb_at, hb_period_min * 60);
    endfunction

    function automatic logic [TIM_W-1:0] next_due_time(input logic [TIM_W-1:0] now);
        if (alert_on) begin
            if (alert_owed && peak.total != 0)
                return now;
            if (last_repeat_at != 0)
                return capped_sum(last_repeat_at, alert_gap_s);
            return now;
        end
        if (idle_owed)
            return now;
        if (last_hb_at != 0)
            return capped_sum(last_hb_at, hb_period_min * 60);
        return now;
    endfunction

    // Advances the predicted state by one event and returns the result it should produce.
    function automatic verdict_t publish_verdict(input event_t ev);
        verdict_t v;
        v.due       = 1'b0;
        v.heartbeat = 1'b0;
        case (ev.kind)
            KIND_SAMPLE: take_sample(ev);
            KIND_POLL: begin
                v.due       = publish_is_due(ev.now);
                v.heartbeat = !alert_on;
            end
            KIND_MARK_DONE: begin
                if (ev.mark_hb) begin
                    last_hb_at = ev.now;
                    idle_owed  = 1'b0;
                end else begin
                    alert_owed     = 1'b0;
                    last_alert_at  = ev.now;
                    last_repeat_at = ev.now;
                    peak           = '0;
                end
            end
            default: begin
                last_alert_at  = '0;
                last_hb_at     = '0;
                last_repeat_at = '0;
                if (alert_on)
                    alert_owed = 1'b1;
                else
                    idle_owed = 1'b1;
            end
        endcase
        v.alert_on = alert_on;
        v.owed     = alert_owed;
        v.peak     = v.heartbeat ? '0 : peak;
        v.next_due = next_due_time(ev.now);
        v.alert_at = last_alert_at;
        return v;
    endfunction

    // ------------------------------------------------------ stimulus helpers
    function automatic event_t mk_event(input logic [1:0] kind, input logic [TIM_W-1:0] now,
                                        input logic [MINUTE_WIDTH-1:0] minute,
                                        input logic [CNT_W-1:0] total, input logic [CNT_W-1:0] c1,
                                        input logic [CNT_W-1:0] c2, input logic [CNT_W-1:0] c3,
                                        input int mark_hb);
        event_t ev;
        ev.kind    = kind;
        ev.now     = now;
        ev.minute  = minute;
        ev.counts  = '{total, c1, c2, c3};
        ev.mark_hb = 1'(mark_hb);
        return ev;
    endfunction

    // Idle cycles before the next transfer; runs of 20..60 transfers are either calm or gappy.
    function automatic int draw_gap(input int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(20, 60);
            run_calm[side] = ($urandom_range(0, 3) == 0);
        end
        run_left[side]--;
        return run_calm[side] ? 0 : $urandom_range(0, 11);
    endfunction

    // Mostly a plausible sensor timeline: time creeping forward, presence in runs,
    // polls answered by the matching mark. A few jumps, rewinds and noise mixed in.
    function automatic event_t next_random_event();
        event_t ev;
        int     pick;
        pick = $urandom_range(0, 99);
        ev.kind = pick < 55 ? KIND_SAMPLE : pick < 80 ? KIND_POLL :
                  pick < 95 ? KIND_MARK_DONE : KIND_RESET_TIMER;

        pick = $urandom_range(0, 99);
        if (pick < 89)
            t_now = t_now + TIM_W'($urandom_range(0, 25));
        else if (pick < 93)
            t_now = t_now - TIM_W'($urandom_range(1, 30));
        else if (pick < 97)
            t_now = t_now + TIM_W'($urandom_range(100, 4000));
        else if (pick < 98)
            t_now = TIM_W'($urandom_range(0, 3));
        else
            t_now = $urandom();
        ev.now = t_now;

        minute_cur = MINUTE_WIDTH'((minute_cur + $urandom_range(0, 2)) % MINUTES_PER_DAY);
        ev.minute = ($urandom_range(0, 99) < 85) ? minute_cur
                                                 : MINUTE_WIDTH'($urandom_range(0, 2047));

        if ($urandom_range(0, 99) < 12)
            presence = !presence;
        if ($urandom_range(0, 99) < 5)
            ev.counts.total = CNT_W'($urandom());
        else if (!presence)
            ev.counts.total = '0;
        else if ($urandom_range(0, 9) == 0)
            ev.counts.total = '1;
        else
            ev.counts.total = CNT_W'($urandom_range(1, 254));
        ev.counts.first  = CNT_W'($urandom());
        ev.counts.second = CNT_W'($urandom());
        ev.counts.third  = CNT_W'($urandom());

        ev.mark_hb = ($urandom_range(0, 3) != 0) ? last_poll_hb : 1'($urandom());
        return ev;
    endfunction

    // ------------------------------------------------------ drivers
    // Holds valid and payload until the transfer; no lowering of valid between back-to-back items.
    task automatic send_event(input event_t ev, input bit typed, input verdict_t typed_v);
        int       gap;
        verdict_t v;
        gap = draw_gap(SIDE_SEND);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_kind           <= ev.kind;
        s_now_seconds    <= ev.now;
        s_minute_of_day  <= ev.minute;
        s_total_count    <= ev.counts.total;
        s_first_count    <= ev.counts.first;
        s_second_count   <= ev.counts.second;
        s_third_count    <= ev.counts.third;
        s_mark_heartbeat <= ev.mark_hb;
        s_valid          <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        v = publish_verdict(ev);
        if (ev.kind == KIND_POLL)
            last_poll_hb = v.heartbeat;
        awaited_verdicts.push_back(typed ? typed_v : v);
        events_sent++;
    endtask

    // Setup then access; psel stays up across back-to-back writes.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_WIDTH'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        apply_register(idx, val);
    endtask

    // Sender holds off until every outstanding result has been transferred.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                     $time, results_seen, what, got, want);
    endtask

    // ------------------------------------------------------ result side
    always begin
        wait (aresetn);
        forever begin
            int gap;
            gap = draw_gap(SIDE_RECV);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready))
                @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        verdict_t got;
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            got.due       = m_publish_due;
            got.heartbeat = m_heartbeat_flag;
            got.alert_on  = m_active;
            got.owed      = m_pending;
            got.peak      = '{m_publish_total, m_publish_first, m_publish_second,
                              m_publish_third};
            got.next_due  = m_next_publish_time;
            got.alert_at  = m_alert_time_reported;
            results_seen++;
            if (awaited_verdicts.size() == 0) begin
                report_mismatch("unexpected transfer, nothing outstanding", 0, 0);
            end else begin
                want = awaited_verdicts.pop_front();
                if (want.due && want.heartbeat)
                    beats_due++;
                else if (want.due)
                    alerts_due++;
                if (got.due !== want.due)
                    report_mismatch("publish_due", got.due, want.due);
                if (got.heartbeat !== want.heartbeat)
                    report_mismatch("heartbeat_flag", got.heartbeat, want.heartbeat);
                if (got.alert_on !== want.alert_on)
                    report_mismatch("active", got.alert_on, want.alert_on);
                if (got.owed !== want.owed)
                    report_mismatch("pending", got.owed, want.owed);
                if (got.peak.total !== want.peak.total)
                    report_mismatch("publish_total", got.peak.total, want.peak.total);
                if (got.peak.first !== want.peak.first)
                    report_mismatch("publish_first", got.peak.first, want.peak.first);
                if (got.peak.second !== want.peak.second)
                    report_mismatch("publish_second", got.peak.second, want.peak.second);
                if (got.peak.third !== want.peak.third)
                    report_mismatch("publish_third", got.peak.third, want.peak.third);
                if (got.next_due !== want.next_due)
                    report_mismatch("next_publish_time", got.next_due, want.next_due);
                if (got.alert_at !== want.alert_at)
                    report_mismatch("alert_time_reported", got.alert_at, want.alert_at);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------ test sequence
    initial begin : main_sequence
        event_t          directed [$];
        verdict_t        typed_at [int];
        verdict_t        none;
        logic [31:0]     setting [6];
        logic [31:0]     fixed_sets [4][6];
        int              set_count;

        none = '{1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0};

        // Out of reset: idle with no heartbeat yet, so a poll wants a heartbeat now.
        directed.push_back(mk_event(KIND_POLL,        32'd100, 11'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0));
        typed_at[0] = '{1'b1, 1'b1, 1'b0, 1'b0, '0, 32'd100, 32'd0};
        // Timer reset raises the idle notice: next publish is immediate.
        directed.push_back(mk_event(KIND_RESET_TIMER, 32'd200, 11'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0));
        typed_at[1] = '{1'b0, 1'b0, 1'b0, 1'b0, '0, 32'd200, 32'd0};
        // Heartbeat at the last second: next time saturates.
        directed.push_back(mk_event(KIND_MARK_DONE, 32'hFFFF_FFFF, 11'd0,
                                    8'd0, 8'd0, 8'd0, 8'd0, 1));
        typed_at[2] = '{1'b0, 1'b0, 1'b0, 1'b0, '0, 32'hFFFF_FFFF, 32'd0};
        // Detection starting at time zero never counts, until it restarts.
        directed.push_back(mk_event(KIND_SAMPLE, 32'd0,  11'd0,    8'd5,   8'd1,   8'd2,   8'd3, 0));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd5,  11'd1439, 8'd5,   8'd1,   8'd2,   8'd3, 0));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd6,  11'd2047, 8'd0,   8'd0,   8'd0,   8'd0, 1));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd10, 11'd100,  8'd1,   8'd255, 8'd0,   8'd255, 0));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd11, 11'd100,  8'd2,   8'd0,   8'd255, 8'd0, 0));
        // Time running backwards does not satisfy the debounce.
        directed.push_back(mk_event(KIND_SAMPLE, 32'd8,  11'd100,  8'd3,   8'd3,   8'd3,   8'd3, 0));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd12, 11'd100,  8'd255, 8'd255, 8'd255, 8'd255, 0));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd13, 11'd100,  8'd7,   8'd9,   8'd9,   8'd9, 0));
        directed.push_back(mk_event(KIND_POLL,   32'd14, 11'd100,  8'd0,   8'd0,   8'd0,   8'd0, 0));
        directed.push_back(mk_event(KIND_MARK_DONE, 32'd15, 11'd100, 8'd0, 8'd0,   8'd0,   8'd0, 0));
        // Active with an empty record: nothing to publish.
        directed.push_back(mk_event(KIND_POLL,   32'd20, 11'd100,  8'd0,   8'd0,   8'd0,   8'd0, 0));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd30, 11'd100,  8'd40,  8'd10,  8'd20,  8'd10, 0));
        directed.push_back(mk_event(KIND_POLL,   32'd40, 11'd100,  8'd0,   8'd0,   8'd0,   8'd0, 0));
        directed.push_back(mk_event(KIND_POLL,   32'd75, 11'd100,  8'd0,   8'd0,   8'd0,   8'd0, 0));
        // Clear period of the same length drops active.
        directed.push_back(mk_event(KIND_SAMPLE, 32'd80, 11'd100,  8'd0,   8'd0,   8'd0,   8'd0, 0));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd81, 11'd100,  8'd0,   8'd0,   8'd0,   8'd0, 0));
        directed.push_back(mk_event(KIND_SAMPLE, 32'd82, 11'd100,  8'd0,   8'd0,   8'd0,   8'd0, 0));
        directed.push_back(mk_event(KIND_POLL,   32'd83, 11'd100,  8'd0,   8'd0,   8'd0,   8'd0, 0));
        directed.push_back(mk_event(KIND_MARK_DONE, 32'd84, 11'd100, 8'd0, 8'd0,   8'd0,   8'd0, 1));
        directed.push_back(mk_event(KIND_RESET_TIMER, 32'd90, 11'd100, 8'd9, 8'd9, 8'd9,   8'd9, 1));
        directed.push_back(mk_event(KIND_POLL,   32'd0,  11'd0,    8'd0,   8'd0,   8'd0,   8'd0, 1));
        directed.push_back(mk_event(KIND_MARK_DONE, 32'h5555_AAAA, 11'd1440,
                                    8'd0, 8'd0, 8'd0, 8'd0, 0));

        // Fixed register sets: wrapping window, non-wrapping window with top limits,
        // equal bounds with writes below the floors, out-of-range writes with schedule off.
        fixed_sets[0] = '{32'd1, 32'd1080, 32'd360, 32'd2,  32'd5,  32'd60};
        fixed_sets[1] = '{32'd1, 32'd300,  32'd900, 32'd20, 32'd60, 32'd300};
        fixed_sets[2] = '{32'd1, 32'd500,  32'd500, 32'd0,  32'd0,  32'd0};
        fixed_sets[3] = '{32'd0, 32'd2047, 32'd1440, 32'd31, 32'd63, 32'd511};
        set_count = 1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_event(directed[i], typed_at.exists(i) != 0,
                       typed_at.exists(i) ? typed_at[i] : none);

        for (int p = 0; p < 4 + RANDOM_SETTINGS; p++) begin
            drain_results();
            if (p < 4)
                setting = fixed_sets[p];
            else
                foreach (setting[r])
                    setting[r] = $urandom();
            foreach (REG_ORDER[r])
                write_register(REG_ORDER[r], setting[r]);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            set_count++;
            minute_cur = MINUTE_WIDTH'($urandom_range(0, 1439));
            for (int n = 0; n < EVENTS_PER_SET; n++) begin
                if (n % 60 == 59)
                    minute_cur = MINUTE_WIDTH'($urandom_range(0, 1439));
                send_event(next_random_event(), 1'b0, none);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d events under %0d register settings, %0d results checked.",
                 events_sent, set_count, results_seen);
        $display("Activations %0d, alerts due %0d, heartbeats due %0d, mismatches %0d.",
                 activations, alerts_due, beats_due, mismatches);
        if (mismatches == 0 && awaited_verdicts.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
